// File: src/fla_pkg.sv
`default_nettype none
package fla_pkg;

    localparam int unsigned FREE_ENTRIES = 32;
    localparam int unsigned HEADER_BYTES = 16;
    localparam int unsigned IDX_W        = $clog2(FREE_ENTRIES);
    localparam int unsigned CNT_W        = $clog2(FREE_ENTRIES + 1);

    localparam logic [2:0] ST_TABLE = 3'd0;
    localparam logic [2:0] ST_GROWN = 3'd1;
    localparam logic [2:0] ST_FREED = 3'd2;
    localparam logic [2:0] ST_OOM   = 3'd3;
    localparam logic [2:0] ST_FULL  = 3'd4;

    localparam logic REG_FIT_POLICY = 1'b0;
    localparam logic REG_HEAP_LIMIT = 1'b1;

    typedef enum logic [2:0] {
        OP_HOLD,
        OP_ROTATE,
        OP_SET,
        OP_REMOVE,
        OP_INSERT,
        OP_COLLAPSE
    } t_cell_op;

    typedef struct packed {
        logic [31:0] start;
        logic [31:0] size;
    } t_entry;

    typedef struct packed {
        t_cell_op        op;
        logic [IDX_W-1:0] idx;
        t_entry          value;
    } t_cell_cmd;

endpackage
`default_nettype wire

// File: src/fla_cell.sv
`default_nettype none
module fla_cell (
    input  wire logic                     i_clk,
    input  wire logic [fla_pkg::IDX_W-1:0] i_index,
    input  fla_pkg::t_cell_cmd            i_cmd,
    input  fla_pkg::t_entry               i_left,
    input  fla_pkg::t_entry               i_right,
    output fla_pkg::t_entry               o_entry
);

    fla_pkg::t_entry r_entry;

    assign o_entry = r_entry;

    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            fla_pkg::OP_ROTATE: r_entry <= i_right;
            fla_pkg::OP_SET: begin
                if (i_index == i_cmd.idx) r_entry <= i_cmd.value;
            end
            fla_pkg::OP_REMOVE: begin
                if (i_index >= i_cmd.idx) r_entry <= i_right;
            end
            fla_pkg::OP_INSERT: begin
                if (i_index > i_cmd.idx) r_entry <= i_left;
                else if (i_index == i_cmd.idx) r_entry <= i_cmd.value;
            end
            fla_pkg::OP_COLLAPSE: begin
                if (i_index > i_cmd.idx) r_entry <= i_right;
                else if (i_index == i_cmd.idx) r_entry <= i_cmd.value;
            end
            default: r_entry <= r_entry;
        endcase
    end

endmodule
`default_nettype wire

// File: src/free_list_heap_allocator.sv
`default_nettype none
// Channel   | Direction | Handshake              | Beat carries
// ----------+-----------+------------------------+------------------------------------------
// request   | in        | i_valid / o_stall      | mode, request_size, block_address, size
// result    | out       | o_valid / i_stall      | offset, granted size, status, totals
// config    | in        | APB psel/penable       | fit_policy (0x0), heap_limit (0x4)
//
// Each beat passes through capture, scan, decide and result steps, plus output stall:
// a capture step, a scan that rotates the cell chain past its head, a decide
// step that also applies the shift, split or merge, and a result step.
// One beat is in flight at a time.
// Reset is synchronous, active low; it clears count, break and free total, and resets config (heap_limit 1048576).
// Table contents are undefined until written; only entries below the count are used.
// A stalled result holds; o_stall stays high until the result beat has gone.
module free_list_heap_allocator (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic        i_mode,
    input  wire logic [31:0] i_request_size,
    input  wire logic [31:0] i_block_address,
    input  wire logic [31:0] i_block_size,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [31:0]      o_payload_offset,
    output logic [31:0]      o_granted_size,
    output logic [2:0]       o_status,
    output logic [31:0]      o_segment_size,
    output logic [31:0]      o_free_bytes,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    localparam int unsigned N = fla_pkg::FREE_ENTRIES;
    localparam logic [33:0] HDR = 34'(fla_pkg::HEADER_BYTES);

    typedef enum logic [1:0] {S_IDLE, S_SCAN, S_DECIDE, S_OUT} t_state;

    t_state r_state;

    // configuration
    logic        r_fit_policy;
    logic [31:0] r_heap_limit;

    // block state
    logic [fla_pkg::CNT_W-1:0] r_count;
    logic [31:0] r_brk;
    logic [31:0] r_ft;

    // captured beat
    logic        r_mode;
    logic [31:0] r_req;
    logic [31:0] r_s;
    logic [31:0] r_bsz;

    // scan trackers
    logic [fla_pkg::IDX_W-1:0] r_k;
    logic        r_found;
    logic        r_exact;
    logic [31:0] r_best;
    logic [fla_pkg::IDX_W-1:0] r_pick;
    fla_pkg::t_entry r_pent;
    logic        r_stop;
    logic [fla_pkg::CNT_W-1:0] r_pos;
    fla_pkg::t_entry r_prev;
    fla_pkg::t_entry r_next;

    fla_pkg::t_entry   w_cell [N];
    fla_pkg::t_cell_cmd w_cmd;

    genvar g;
    generate
        for (g = 0; g < N; g++) begin : g_cell
            fla_cell u_cell (
                .i_clk   (i_clk),
                .i_index (fla_pkg::IDX_W'(g)),
                .i_cmd   (w_cmd),
                .i_left  (w_cell[(g + N - 1) % N]),
                .i_right (w_cell[(g + 1) % N]),
                .o_entry (w_cell[g])
            );
        end
    endgenerate

    function automatic logic [31:0] sat32(input logic [33:0] v);
        sat32 = (v[33:32] != 2'b00) ? 32'hFFFF_FFFF : v[31:0];
    endfunction

    // config port: always ready, read returns the register
    assign pready = 1'b1;
    always_comb begin
        unique case (paddr[2])
            fla_pkg::REG_FIT_POLICY: prdata = {31'd0, r_fit_policy};
            fla_pkg::REG_HEAP_LIMIT: prdata = r_heap_limit;
            default:                 prdata = 32'd0;
        endcase
    end

    assign o_stall        = (r_state != S_IDLE);
    assign o_valid        = (r_state == S_OUT);
    assign o_segment_size = r_brk;
    assign o_free_bytes   = r_ft;

    // head of chain during the scan is entry r_k
    fla_pkg::t_entry w_head;
    logic        w_hvalid;
    logic        w_fits;
    logic [31:0] w_diff;
    assign w_head   = w_cell[0];
    assign w_hvalid = (fla_pkg::CNT_W'(r_k) < r_count);
    assign w_fits   = w_hvalid && (w_head.size >= r_req);
    assign w_diff   = w_head.size - r_req;

    // decide-cycle arithmetic
    logic        w_split;
    logic [33:0] w_nb;
    logic        w_mp;
    logic        w_ms;
    logic [33:0] w_prev_end;
    logic [33:0] w_new_end;
    logic [fla_pkg::IDX_W-1:0] w_pos_idx;
    logic [fla_pkg::IDX_W-1:0] w_prev_idx;

    always_comb begin
        w_split = r_fit_policy ? (!r_exact && (r_best >= 32'(fla_pkg::HEADER_BYTES)))
                               : ({2'b00, r_pent.size} > ({2'b00, r_req} + HDR));
        w_nb       = {2'b00, r_brk} + {2'b00, r_req} + HDR;
        w_prev_end = {2'b00, r_prev.start} + HDR + {2'b00, r_prev.size};
        w_new_end  = {2'b00, r_s} + HDR + {2'b00, r_bsz};
        w_mp       = (r_pos != '0) && (w_prev_end == {2'b00, r_s});
        w_ms       = r_stop && (w_new_end == {2'b00, r_next.start});
        w_pos_idx  = r_pos[fla_pkg::IDX_W-1:0];
        w_prev_idx = w_pos_idx - 1'b1;
    end

    // cell command
    always_comb begin
        w_cmd.op    = fla_pkg::OP_HOLD;
        w_cmd.idx   = '0;
        w_cmd.value = '0;
        if (r_state == S_SCAN) begin
            w_cmd.op = fla_pkg::OP_ROTATE;
        end else if (r_state == S_DECIDE) begin
            if (!r_mode) begin
                if (r_found) begin
                    w_cmd.idx = r_pick;
                    if (w_split) begin
                        w_cmd.op          = fla_pkg::OP_SET;
                        w_cmd.value.start = r_pent.start + r_req + 32'(fla_pkg::HEADER_BYTES);
                        w_cmd.value.size  = r_pent.size - r_req - 32'(fla_pkg::HEADER_BYTES);
                    end else begin
                        w_cmd.op = fla_pkg::OP_REMOVE;
                    end
                end
            end else if (w_mp && w_ms) begin
                w_cmd.op          = fla_pkg::OP_COLLAPSE;
                w_cmd.idx         = w_prev_idx;
                w_cmd.value.start = r_prev.start;
                w_cmd.value.size  = sat32({2'b00, r_prev.size} + w_new_end
                                          - {2'b00, r_s} + HDR + {2'b00, r_next.size});
            end else if (w_mp) begin
                w_cmd.op          = fla_pkg::OP_SET;
                w_cmd.idx         = w_prev_idx;
                w_cmd.value.start = r_prev.start;
                w_cmd.value.size  = sat32({2'b00, r_prev.size} + HDR + {2'b00, r_bsz});
            end else if (w_ms) begin
                w_cmd.op          = fla_pkg::OP_SET;
                w_cmd.idx         = w_pos_idx;
                w_cmd.value.start = r_s;
                w_cmd.value.size  = sat32({2'b00, r_bsz} + HDR + {2'b00, r_next.size});
            end else if (r_count != fla_pkg::CNT_W'(N)) begin
                w_cmd.op          = fla_pkg::OP_INSERT;
                w_cmd.idx         = w_pos_idx;
                w_cmd.value.start = r_s;
                w_cmd.value.size  = r_bsz;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_fit_policy <= 1'b0;
            r_heap_limit <= 32'd1048576;
            r_count      <= '0;
            r_brk        <= '0;
            r_ft         <= '0;
        end else begin
            // register writes land on the access phase
            if (psel && penable && pwrite && pready) begin
                unique case (paddr[2])
                    fla_pkg::REG_FIT_POLICY: r_fit_policy <= pwdata[0];
                    fla_pkg::REG_HEAP_LIMIT: r_heap_limit <= pwdata;
                    default: ;
                endcase
            end

            unique case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_mode  <= i_mode;
                        r_req   <= i_request_size;
                        r_s     <= i_block_address - 32'(fla_pkg::HEADER_BYTES);
                        r_bsz   <= i_block_size;
                        r_k     <= '0;
                        r_found <= 1'b0;
                        r_exact <= 1'b0;
                        r_stop  <= 1'b0;
                        r_pos   <= '0;
                        r_state <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    if (!r_mode) begin
                        if (!r_fit_policy) begin
                            // first fit: lock on the first block large enough
                            if (w_fits && !r_found) begin
                                r_found <= 1'b1;
                                r_pick  <= r_k;
                                r_pent  <= w_head;
                            end
                        end else if (w_fits && !r_exact) begin
                            // best fit: exact match wins, else smallest remainder
                            if (w_diff == 32'd0 || !r_found || w_diff < r_best) begin
                                r_found <= 1'b1;
                                r_exact <= (w_diff == 32'd0);
                                r_best  <= w_diff;
                                r_pick  <= r_k;
                                r_pent  <= w_head;
                            end
                        end
                    end else if (w_hvalid && !r_stop) begin
                        // free: find the first start strictly above the new one
                        if (w_head.start > r_s) begin
                            r_stop <= 1'b1;
                            r_next <= w_head;
                        end else begin
                            r_prev <= w_head;
                            r_pos  <= r_pos + 1'b1;
                        end
                    end
                    r_k <= r_k + 1'b1;
                    if (r_k == fla_pkg::IDX_W'(N - 1)) r_state <= S_DECIDE;
                end
                S_DECIDE: begin
                    r_state <= S_OUT;
                    if (!r_mode) begin
                        if (r_found) begin
                            o_status         <= fla_pkg::ST_TABLE;
                            o_payload_offset <= r_pent.start + 32'(fla_pkg::HEADER_BYTES);
                            if (w_split) begin
                                o_granted_size <= r_req;
                                r_ft <= r_ft - r_req - 32'(fla_pkg::HEADER_BYTES);
                            end else begin
                                o_granted_size <= r_pent.size;
                                r_ft    <= r_ft - r_pent.size - 32'(fla_pkg::HEADER_BYTES);
                                r_count <= r_count - 1'b1;
                            end
                        end else if (w_nb > {2'b00, r_heap_limit}) begin
                            o_status         <= fla_pkg::ST_OOM;
                            o_payload_offset <= '0;
                            o_granted_size   <= '0;
                        end else begin
                            o_status         <= fla_pkg::ST_GROWN;
                            o_payload_offset <= r_brk + 32'(fla_pkg::HEADER_BYTES);
                            o_granted_size   <= r_req;
                            r_brk            <= w_nb[31:0];
                        end
                    end else begin
                        o_payload_offset <= '0;
                        o_granted_size   <= '0;
                        if (!w_mp && !w_ms && r_count == fla_pkg::CNT_W'(N)) begin
                            o_status <= fla_pkg::ST_FULL;
                        end else begin
                            o_status <= fla_pkg::ST_FREED;
                            r_ft     <= r_ft + r_bsz + 32'(fla_pkg::HEADER_BYTES);
                            if (w_mp && w_ms) r_count <= r_count - 1'b1;
                            else if (!w_mp && !w_ms) r_count <= r_count + 1'b1;
                        end
                    end
                end
                S_OUT: begin
                    if (!i_stall) r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule
`default_nettype wire
